[rtl/led_blink_pattern_sequencer_assert.svh]
// assertion macros used by the led blink pattern sequencer controller
`ifndef LED_BLINK_PATTERN_SEQUENCER_ASSERT_SVH
`define LED_BLINK_PATTERN_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during reset
`define LBPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbps assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define LBPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbps assertion failed");

`else

`define LBPS_ASSERT_NOW(label, ante, cons)
`define LBPS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[rtl/lbps_pkg.sv]
// types and constants of the led blink pattern sequencer
`default_nettype none

package lbps_pkg;

  localparam int CNT_W   = 7;
  localparam int NOTE_W  = 7;
  localparam int REP_W   = 8;
  localparam int SCALE_W = 8;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd1;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_CLEAR,
    S_VISIT,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [1:0]        channel;
    logic              red_on;
    logic              green_on;
    logic              blue_on;
    logic [CNT_W-1:0]  on_frames;
    logic [CNT_W-1:0]  off_frames;
    logic [REP_W-1:0]  repeats;
    logic [NOTE_W-1:0] base_note;
    logic [NOTE_W-1:0] note_step;
  } item_t;

  typedef struct packed {
    logic               led_write;
    logic [SCALE_W-1:0] led_red;
    logic [SCALE_W-1:0] led_green;
    logic [SCALE_W-1:0] led_blue;
    logic               note_valid;
    logic [NOTE_W-1:0]  note_number;
    logic               last_event;
  } res_t;

  typedef struct packed {
    logic latch;
    logic load;
    logic clear;
    logic visit;
    logic emit;
    logic emit_last;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] in_cmd;
    logic       start_ok;
    logic       clear_ok;
    logic       evt_res;
    logic       pend_v;
    logic       out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/lbps_if.sv]
// input and result channel interfaces of the led blink pattern sequencer
`default_nettype none

interface lbps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [1:0] channel;
  logic       red_on;
  logic       green_on;
  logic       blue_on;
  logic [6:0] on_frames;
  logic [6:0] off_frames;
  logic [7:0] repeats;
  logic [6:0] base_note;
  logic [6:0] note_step;

  modport source (
    output valid, cmd, channel, red_on, green_on, blue_on, on_frames, off_frames,
           repeats, base_note, note_step,
    input  ready
  );
  modport sink (
    input  valid, cmd, channel, red_on, green_on, blue_on, on_frames, off_frames,
           repeats, base_note, note_step,
    output ready
  );
endinterface

interface lbps_out_if;
  logic       valid;
  logic       ready;
  logic       led_write;
  logic [7:0] led_red;
  logic [7:0] led_green;
  logic [7:0] led_blue;
  logic       note_valid;
  logic [6:0] note_number;
  logic       last_event;

  modport source (
    output valid, led_write, led_red, led_green, led_blue, note_valid, note_number,
           last_event,
    input  ready
  );
  modport sink (
    input  valid, led_write, led_red, led_green, led_blue, note_valid, note_number,
           last_event,
    output ready
  );
endinterface

`default_nettype wire

[rtl/lbps_ctrl.sv]
// controller state machine: command decode and channel visit sequencing
`default_nettype none
`include "led_blink_pattern_sequencer_assert.svh"

module lbps_ctrl
  import lbps_pkg::*;
#(
  parameter int NUM_CHANNELS = 2,
  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire dp_stat_t        stat,
  output ctl_cmd_t             cmd,
  output logic [CH_W-1:0]      idx
);

  localparam logic [CH_W-1:0] LAST_IDX = CH_W'(NUM_CHANNELS - 1);

  state_t            state_r, state_nxt;
  logic [CH_W-1:0]   idx_r, idx_nxt;
  logic              stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    in_ready  = 1'b0;
    stall     = stat.evt_res && stat.pend_v && !stat.out_free;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          case (stat.in_cmd)
            CMD_TICK: begin
              state_nxt = S_VISIT;
              idx_nxt   = '0;
            end
            CMD_START: if (stat.start_ok) state_nxt = S_LOAD;
            CMD_CLEAR: if (stat.clear_ok) state_nxt = S_CLEAR;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_CLEAR: begin
        cmd.clear = 1'b1;
        state_nxt = S_FLUSH;
      end
      S_VISIT: begin
        if (!stall) begin
          cmd.visit = 1'b1;
          cmd.emit  = stat.evt_res && stat.pend_v;
          if (idx_r == LAST_IDX) begin
            state_nxt = S_FLUSH;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (!stat.pend_v) begin
          state_nxt = S_IDLE;
        end else if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign idx = idx_r;

  `LBPS_ASSERT_NOW(a_emit_room, cmd.emit, stat.out_free)
  `LBPS_ASSERT_NOW(a_no_overwrite, cmd.visit && stat.evt_res && stat.pend_v, cmd.emit)
  `LBPS_ASSERT_NEXT(a_flush_empty, state_r == S_FLUSH && state_nxt == S_IDLE, !stat.pend_v)
  `LBPS_ASSERT_NOW(a_work_not_idle, cmd.visit || cmd.load || cmd.clear, !in_ready)

endmodule

`default_nettype wire

[rtl/lbps_dp.sv]
// datapath: channel pattern registers, event detect, pending and output result registers
`default_nettype none

module lbps_dp
  import lbps_pkg::*;
#(
  parameter int NUM_CHANNELS = 2,
  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [SCALE_W-1:0] cfg_wdata,
  input  wire item_t              in_item,
  input  wire ctl_cmd_t           cmd,
  input  wire logic [CH_W-1:0]    idx,
  output dp_stat_t                stat,
  output res_t                    out_data,
  output logic                    out_valid,
  input  wire logic               out_ready
);

  logic [SCALE_W-1:0] scale_r;
  item_t              item_r;
  logic               lit_r   [NUM_CHANNELS];
  logic [CNT_W-1:0]   cnt_r   [NUM_CHANNELS];
  logic [REP_W-1:0]   rep_r   [NUM_CHANNELS];
  logic [CNT_W-1:0]   on_r    [NUM_CHANNELS];
  logic [CNT_W-1:0]   off_r   [NUM_CHANNELS];
  logic [2:0]         col_r   [NUM_CHANNELS];
  logic [NOTE_W-1:0]  note_r  [NUM_CHANNELS];
  logic [NOTE_W-1:0]  step_r  [NUM_CHANNELS];
  logic [CH_W-1:0]    owner_r;
  res_t               pend_r;
  logic               pend_v_r;
  res_t               out_r;
  logic               out_v_r;

  logic               act, go_off, go_on, note_v, evt_res;
  logic [CH_W-1:0]    ch_idx;
  logic               clear_all, clr_res;
  res_t               off_res, on_res;
  res_t               emit_res;

  function automatic res_t make_res(input logic [SCALE_W-1:0] s, input logic [2:0] col,
                                    input logic nv, input logic [NOTE_W-1:0] note);
    res_t r;
    r.led_write   = 1'b1;
    r.led_red     = col[0] ? s : '0;
    r.led_green   = col[1] ? s : '0;
    r.led_blue    = col[2] ? s : '0;
    r.note_valid  = nv;
    r.note_number = nv ? note : '0;
    r.last_event  = 1'b0;
    return r;
  endfunction

  // event detect for the channel under visit
  always_comb begin
    act     = rep_r[idx] != '0;
    go_off  = act && lit_r[idx] && (cnt_r[idx] == on_r[idx]);
    go_on   = act && !lit_r[idx] && (cnt_r[idx] == off_r[idx]);
    note_v  = note_r[idx] != '0;
    evt_res = go_on || (go_off && (owner_r == idx));
    on_res  = make_res(scale_r, col_r[idx], note_v, note_r[idx]);
    off_res = make_res(scale_r, 3'b000, 1'b0, '0);
  end

  assign ch_idx    = CH_W'(item_r.channel);
  assign clear_all = int'(item_r.channel) == NUM_CHANNELS;
  assign clr_res   = clear_all || (int'(owner_r) == int'(item_r.channel));

  always_comb begin
    stat.in_cmd   = in_item.cmd;
    stat.start_ok = int'(in_item.channel) < NUM_CHANNELS;
    stat.clear_ok = int'(in_item.channel) <= NUM_CHANNELS;
    stat.evt_res  = evt_res;
    stat.pend_v   = pend_v_r;
    stat.out_free = !out_v_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_we) begin
      scale_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_item;
    end
  end

  // per-channel pattern state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        lit_r[i]  <= 1'b0;
        cnt_r[i]  <= '0;
        rep_r[i]  <= '0;
        on_r[i]   <= '0;
        off_r[i]  <= '0;
        col_r[i]  <= '0;
        note_r[i] <= '0;
        step_r[i] <= '0;
      end
      owner_r <= '0;
    end else begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (cmd.load && (CH_W'(i) == ch_idx)) begin
          lit_r[i]  <= 1'b0;
          cnt_r[i]  <= '0;
          col_r[i]  <= {item_r.blue_on, item_r.green_on, item_r.red_on};
          on_r[i]   <= item_r.on_frames;
          off_r[i]  <= item_r.off_frames;
          rep_r[i]  <= item_r.repeats;
          note_r[i] <= item_r.base_note;
          step_r[i] <= item_r.note_step;
        end
        if (cmd.clear && (clear_all || (CH_W'(i) == ch_idx))) begin
          rep_r[i]  <= '0;
          on_r[i]   <= '0;
          off_r[i]  <= '0;
          col_r[i]  <= '0;
          note_r[i] <= '0;
          step_r[i] <= '0;
        end
        if (cmd.visit && act && (CH_W'(i) == idx)) begin
          if (go_off) begin
            lit_r[i] <= 1'b0;
            cnt_r[i] <= CNT_W'(1);
            rep_r[i] <= rep_r[i] - 1'b1;
          end else if (go_on) begin
            lit_r[i] <= 1'b1;
            cnt_r[i] <= CNT_W'(1);
            if (note_v) begin
              note_r[i] <= note_r[i] + step_r[i];
            end
          end else begin
            cnt_r[i] <= cnt_r[i] + 1'b1;
          end
        end
      end
      if (cmd.visit && go_on) begin
        owner_r <= idx;
      end
    end
  end

  // one result held back so the last beat of an item can be marked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (cmd.visit && evt_res) begin
      pend_v_r <= 1'b1;
    end else if (cmd.clear && clr_res) begin
      pend_v_r <= 1'b1;
    end else if (cmd.emit) begin
      pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.visit && evt_res) begin
      pend_r <= go_on ? on_res : off_res;
    end else if (cmd.clear && clr_res) begin
      pend_r <= off_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (cmd.emit) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_comb begin
    emit_res            = pend_r;
    emit_res.last_event = cmd.emit_last;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r <= emit_res;
    end
  end

  assign out_data  = out_r;
  assign out_valid = out_v_r;

endmodule

`default_nettype wire

[rtl/led_blink_pattern_sequencer.sv]
// led blink pattern sequencer: multi-channel rgb blink patterns with notes
//
// in_ch takes one command beat: frame tick, start of a pattern on one channel,
// or clear of one channel or of all (channel equal to NUM_CHANNELS).
// out_ch gives led colour beats; last_event marks the final beat of a command.
// cfg_we/cfg_wdata write the brightness scale; write it only while idle.
// a start passes through the load state and gives no beat; a clear of all
// channels or of the channel that owns the led gives its beat from the
// flush state; a tick is accepted in idle, then the state machine visits
// each channel in order and ends in the flush state.
// one result is held back until the next one or the end of the visit pass
// is known, so last_event can be set; the output register frees in_ch from
// out_ch, and a new beat is taken while a result still waits.
// when out_ch stalls, the visit pass holds on the channel that has a second
// result ready, and the flush cycle holds on a waiting result, until the
// output register frees up.
// reset clears every channel's pattern and phase, gives the led to channel 0
// and sets the brightness scale to 1.
`default_nettype none

module led_blink_pattern_sequencer
  import lbps_pkg::*;
#(
  parameter int NUM_CHANNELS = 2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  lbps_in_if.sink                 in_ch,
  lbps_out_if.source              out_ch,
  input  wire logic               cfg_we,
  input  wire logic [SCALE_W-1:0] cfg_wdata
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  item_t            in_item;
  ctl_cmd_t         cmd;
  dp_stat_t         stat;
  logic [CH_W-1:0]  idx;
  res_t             out_data;
  logic             out_valid;
  logic             in_ready;

  always_comb begin
    in_item.cmd        = in_ch.cmd;
    in_item.channel    = in_ch.channel;
    in_item.red_on     = in_ch.red_on;
    in_item.green_on   = in_ch.green_on;
    in_item.blue_on    = in_ch.blue_on;
    in_item.on_frames  = in_ch.on_frames;
    in_item.off_frames = in_ch.off_frames;
    in_item.repeats    = in_ch.repeats;
    in_item.base_note  = in_ch.base_note;
    in_item.note_step  = in_ch.note_step;
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.led_write   = out_data.led_write;
  assign out_ch.led_red     = out_data.led_red;
  assign out_ch.led_green   = out_data.led_green;
  assign out_ch.led_blue    = out_data.led_blue;
  assign out_ch.note_valid  = out_data.note_valid;
  assign out_ch.note_number = out_data.note_number;
  assign out_ch.last_event  = out_data.last_event;

  lbps_ctrl #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd),
    .idx      (idx)
  );

  lbps_dp #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .idx       (idx),
    .stat      (stat),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ch.ready)
  );

endmodule

`default_nettype wire
